[sv/afc_pkg.sv]
package afc_pkg;

  // Default canvas limits handed to the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Width of the canvas size registers.
  localparam int CFG_W = 9;

  // Shared divider geometry: dividend and divisor widths.
  localparam int DIV_NW = 26;
  localparam int DIV_DW = 16;

  // Input item kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Dispose modes.
  localparam logic [1:0] DISP_NONE    = 2'd0;
  localparam logic [1:0] DISP_CLEAR   = 2'd1;
  localparam logic [1:0] DISP_RESTORE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Result kinds.
  localparam logic RES_DELAY = 1'b0;
  localparam logic RES_PIXEL = 1'b1;

  // Arithmetic constants.
  localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
  localparam logic [15:0] DEN_DEFAULT = 16'd100;
  localparam logic [25:0] MIN_DELAY   = 26'd10;
  localparam logic [7:0]  CH_MAX      = 8'd255;
  localparam logic [15:0] ROUND_HALF  = 16'd127;

  typedef struct packed {
    logic [1:0]  kind;
    logic        first_frame;
    logic [7:0]  region_x;
    logic [7:0]  region_y;
    logic [8:0]  region_w;
    logic [8:0]  region_h;
    logic [1:0]  dispose_mode;
    logic        blend_mode;
    logic [15:0] delay_num;
    logic [15:0] delay_den;
    logic [31:0] pixel_bgra;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [25:0] delay_ms;
    logic [31:0] out_pixel;
    logic        last_pixel;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic clr_all;
    logic clr_reg;
    logic copy_b2c;
    logic copy_c2b;
    logic frame_load;
    logic div_delay;
    logic div_chan;
    logic pix_rd;
    logic pix_mul;
    logic pix_wr;
    logic pix_adv;
    logic rd_addr;
    logic rd_data;
    logic chan_next;
    logic out_delay;
    logic out_pix;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       first_frame;
    logic [1:0] pend;
    logic [1:0] dm_new;
    logic       full_last;
    logic       reg_last;
    logic       pix_ok;
    logic       pix_in;
    logic       div_done;
    logic       alpha_zero;
    logic       chan_last;
    logic       out_free;
  } stat_t;

  // Rounded product scaling: (p + 127) / 255 for p up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [15:0] x;
    logic [8:0]  q;
    logic [8:0]  r;
    x = p + ROUND_HALF;
    q = {1'b0, x[15:8]};
    r = {1'b0, x[7:0]} + q;
    if (r >= {1'b0, CH_MAX}) q = q + 9'd1;
    return q[7:0];
  endfunction

endpackage

[sv/animated_frame_compositor.sv]
// Animated frame compositor. The block keeps a premultiplied BGRA canvas in a
// single-port-write memory of MAX_WIDTH * MAX_HEIGHT words, plus a backup
// memory of the same size, and applies frame headers, subframe pixels and
// readout steps one beat at a time. After reset the canvas is cleared by a
// pass over all MAX_WIDTH * MAX_HEIGHT words (65536 with the defaults) during
// which no input beat is taken; configuration writes are taken at any time.
// A subframe pixel goes through decode, canvas read, blend multiply and
// write-back, the read-modify-write on the canvas memory; a pixel that is
// dropped or falls outside the canvas ends after decode. A readout step for
// a visible pixel un-premultiplies the three color channels one after
// another in the bit-serial divider; a transparent one skips the divider.
// A frame header runs the delay division, plus a pass over every canvas
// word for a first-frame clear or a restore, a walk over the region pixels
// for a clear dispose, and one more full pass when the new frame asks for
// restore. Results sit in an output register, so a new beat is accepted
// while the previous result is still stalled.
module animated_frame_compositor #(
  parameter int MAX_WIDTH  = afc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = afc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  afc_pkg::in_t             in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output afc_pkg::out_t            out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [afc_pkg::CFG_W-1:0] cfg_data
);
  import afc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Size registers are plain flops, so a write is always taken.
  assign cfg_ready = 1'b1;

  // The controller sequences every item; the datapath owns the memories,
  // counters, compositing arithmetic, divider and output register.
  afc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  afc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sv/afc_div.sv]
module afc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [afc_pkg::DIV_NW-1:0] dividend,
  input  logic [afc_pkg::DIV_DW-1:0] divisor,
  output logic                      done,
  output logic [afc_pkg::DIV_NW-1:0] quotient
);
  import afc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW:0]   diff;
  logic              ge;
  logic [DIV_DW-1:0] rem_next;

  // One restoring step per cycle, most significant quotient bit first.
  always_comb begin
    sh       = {rem, quo[DIV_NW-1]};
    ge       = sh >= {1'b0, dvs};
    diff     = sh - {1'b0, dvs};
    rem_next = ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_NW-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

[sv/afc_dp.sv]
module afc_dp #(
  parameter int MAX_WIDTH  = afc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = afc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  afc_pkg::cmd_t            cmd,
  output afc_pkg::stat_t           stat,
  input  afc_pkg::in_t             in_data,
  input  logic                     cfg_valid,
  input  logic                     cfg_index,
  input  logic [afc_pkg::CFG_W-1:0] cfg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output afc_pkg::out_t            out_data
);
  import afc_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Canvas size registers and their clamped values.
  logic [CFG_W-1:0]   cfg_w, cfg_h, eff_w, eff_h;
  logic [2*CFG_W-1:0] area;
  logic [AW:0]        total;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= CFG_W'(256);
      cfg_h <= CFG_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  cfg_w <= cfg_data;
        CFG_HEIGHT: cfg_h <= cfg_data;
        default:    cfg_w <= cfg_w;
      endcase
    end
  end

  always_comb begin
    if (cfg_w == '0) eff_w = CFG_W'(1);
    else if (int'(cfg_w) > MAX_WIDTH) eff_w = CFG_W'(MAX_WIDTH);
    else eff_w = cfg_w;
    if (cfg_h == '0) eff_h = CFG_W'(1);
    else if (int'(cfg_h) > MAX_HEIGHT) eff_h = CFG_W'(MAX_HEIGHT);
    else eff_h = cfg_h;
    area  = eff_w * eff_h;
    total = (AW + 1)'(area);
  end

  // Accepted item.
  in_t inq;
  always_ff @(posedge clk) begin
    if (cmd.load_in) inq <= in_data;
  end

  // Frame state.
  logic [7:0]    fx, fy;
  logic [8:0]    fw, fh;
  logic [1:0]    pend;
  logic          blend;
  logic [8:0]    wcol, wrow;
  logic [AW-1:0] ridx;
  logic [1:0]    dm_new;
  logic [9:0]    xend, yend;
  logic          fallback;

  always_comb begin
    dm_new   = (inq.dispose_mode == 2'd3) ? DISP_NONE : inq.dispose_mode;
    xend     = {2'b0, inq.region_x} + {1'b0, inq.region_w};
    yend     = {2'b0, inq.region_y} + {1'b0, inq.region_h};
    fallback = (inq.region_w == '0) || (inq.region_h == '0) ||
               (xend > {1'b0, eff_w}) || (yend > {1'b0, eff_h});
  end

  // Readout index with its restart rule.
  logic [AW-1:0] ridx_eff;
  logic [AW:0]   ridx_inc;
  always_comb begin
    ridx_eff = ({1'b0, ridx} >= total) ? '0 : ridx;
    ridx_inc = {1'b0, ridx_eff} + 1'b1;
  end

  // Sweep counters for full-store passes and region clears.
  logic [AW-1:0] scnt;
  logic [8:0]    rc, cc;
  logic          full_last, reg_last;
  assign full_last = (scnt == AW'(DEPTH - 1));
  assign reg_last  = (rc == fh - 9'd1) && (cc == fw - 9'd1);

  // Canvas coordinate of the region walk or of the next subframe pixel.
  logic [8:0]       sel_row, sel_col;
  logic [9:0]       px, py;
  logic             in_b;
  logic [CFG_W+9:0] prod;
  logic [AW-1:0]    xy_addr;
  always_comb begin
    sel_row = cmd.clr_reg ? rc : wrow;
    sel_col = cmd.clr_reg ? cc : wcol;
    px      = {2'b0, fx} + {1'b0, sel_col};
    py      = {2'b0, fy} + {1'b0, sel_row};
    in_b    = (px < {1'b0, eff_w}) && (py < {1'b0, eff_h});
    prod    = py * eff_w;
    xy_addr = AW'(prod + (CFG_W + 10)'(px));
  end

  // Bounds check of the next subframe pixel for the controller. It looks at
  // the write position only, so the status never depends on a command.
  logic [9:0] wpx, wpy;
  logic       pix_in;
  always_comb begin
    wpx    = {2'b0, fx} + {1'b0, wcol};
    wpy    = {2'b0, fy} + {1'b0, wrow};
    pix_in = (wpx < {1'b0, eff_w}) && (wpy < {1'b0, eff_h});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fx    <= '0;
      fy    <= '0;
      fw    <= '0;
      fh    <= '0;
      pend  <= DISP_NONE;
      blend <= 1'b0;
      wcol  <= '0;
      wrow  <= '0;
      ridx  <= '0;
      scnt  <= '0;
      rc    <= '0;
      cc    <= '0;
    end else begin
      if (cmd.clr_all || cmd.copy_b2c || cmd.copy_c2b) begin
        scnt <= full_last ? '0 : scnt + 1'b1;
      end
      if (cmd.clr_reg) begin
        if (cc == fw - 9'd1) begin
          cc <= '0;
          rc <= reg_last ? '0 : rc + 9'd1;
        end else begin
          cc <= cc + 9'd1;
        end
      end
      if (cmd.frame_load) begin
        fx    <= fallback ? '0 : inq.region_x;
        fy    <= fallback ? '0 : inq.region_y;
        fw    <= fallback ? eff_w : inq.region_w;
        fh    <= fallback ? eff_h : inq.region_h;
        blend <= inq.blend_mode;
        pend  <= dm_new;
        wcol  <= '0;
        wrow  <= '0;
        ridx  <= '0;
      end
      if (cmd.pix_wr || cmd.pix_adv) begin
        if (wcol + 9'd1 >= fw) begin
          wcol <= '0;
          wrow <= wrow + 9'd1;
        end else begin
          wcol <= wcol + 9'd1;
        end
      end
      if (cmd.rd_addr) begin
        ridx <= (ridx_inc >= total) ? '0 : ridx_inc[AW-1:0];
      end
    end
  end

  // Canvas and backup stores.
  logic [31:0]   canvas_mem [DEPTH];
  logic [31:0]   backup_mem [DEPTH];
  logic [31:0]   canvas_q, backup_q;
  logic [AW-1:0] c_raddr, c_waddr, cp_addr;
  logic          c_we, cp_v, cp_c2b;
  logic [31:0]   c_wdata, comp_px;

  always_comb begin
    if (cmd.copy_c2b) c_raddr = scnt;
    else if (cmd.rd_addr) c_raddr = ridx_eff;
    else c_raddr = xy_addr;
  end

  always_comb begin
    c_we    = 1'b0;
    c_waddr = xy_addr;
    c_wdata = '0;
    if (cmd.clr_all) begin
      c_we    = 1'b1;
      c_waddr = scnt;
    end else if (cmd.clr_reg) begin
      c_we = in_b;
    end else if (cp_v && !cp_c2b) begin
      c_we    = 1'b1;
      c_waddr = cp_addr;
      c_wdata = backup_q;
    end else if (cmd.pix_wr) begin
      c_we    = 1'b1;
      c_wdata = comp_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_v <= 1'b0;
    end else begin
      cp_v <= cmd.copy_b2c || cmd.copy_c2b;
    end
  end

  always_ff @(posedge clk) begin
    cp_c2b  <= cmd.copy_c2b;
    cp_addr <= scnt;
  end

  always_ff @(posedge clk) begin
    canvas_q <= canvas_mem[c_raddr];
    if (c_we) canvas_mem[c_waddr] <= c_wdata;
  end

  always_ff @(posedge clk) begin
    backup_q <= backup_mem[scnt];
    if (cp_v && cp_c2b) backup_mem[cp_addr] <= canvas_q;
  end

  // Compositing: premultiply, then scale the destination by 255 - alpha.
  logic [7:0]  sa, pb, pg, pr, qb, qg, qr, qa;
  logic        dst_az;
  logic [7:0]  sa_in, ia;
  logic [15:0] mb, mg, mr, nb, ng, nr, na;

  always_comb begin
    sa_in = inq.pixel_bgra[31:24];
    mb    = inq.pixel_bgra[7:0] * sa_in;
    mg    = inq.pixel_bgra[15:8] * sa_in;
    mr    = inq.pixel_bgra[23:16] * sa_in;
    ia    = CH_MAX - sa;
    nb    = canvas_q[7:0] * ia;
    ng    = canvas_q[15:8] * ia;
    nr    = canvas_q[23:16] * ia;
    na    = canvas_q[31:24] * ia;
    if (!blend || dst_az) begin
      comp_px = {sa, pr, pg, pb};
    end else begin
      comp_px = {sa + qa, pr + qr, pg + qg, pb + qb};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_rd) begin
      sa <= sa_in;
      pb <= div255(mb);
      pg <= div255(mg);
      pr <= div255(mr);
    end
    if (cmd.pix_mul) begin
      qb     <= div255(nb);
      qg     <= div255(ng);
      qr     <= div255(nr);
      qa     <= div255(na);
      dst_az <= (canvas_q[31:24] == '0);
    end
  end

  // Readout and the shared divider.
  logic [31:0]       rpix;
  logic              rlast;
  logic [1:0]        rch;
  logic [2:0][7:0]   rres;
  logic [7:0]        chan_c;
  logic [15:0]       cscaled;
  logic [DIV_NW-1:0] num_ms, div_nd, div_q;
  logic [DIV_DW-1:0] div_dv;
  logic              div_done;
  logic [7:0]        chan_sat;
  logic [25:0]       ms;

  always_comb begin
    unique case (rch)
      2'd0:    chan_c = rpix[7:0];
      2'd1:    chan_c = rpix[15:8];
      default: chan_c = rpix[23:16];
    endcase
    cscaled = chan_c * CH_MAX + {9'd0, rpix[31:25]};
    num_ms  = inq.delay_num * MS_PER_SEC;
    if (cmd.div_delay) begin
      div_nd = num_ms;
      div_dv = (inq.delay_den == '0) ? DEN_DEFAULT : inq.delay_den;
    end else begin
      div_nd = DIV_NW'(cscaled);
      div_dv = DIV_DW'(rpix[31:24]);
    end
    chan_sat = (div_q > DIV_NW'(CH_MAX)) ? CH_MAX : div_q[7:0];
    ms       = (div_q < MIN_DELAY) ? MIN_DELAY : div_q;
  end

  afc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_delay || cmd.div_chan),
    .dividend (div_nd),
    .divisor  (div_dv),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_addr) rlast <= ({1'b0, ridx_eff} == total - 1'b1);
    if (cmd.rd_data) begin
      rpix <= canvas_q;
      rch  <= 2'd0;
    end
    if (cmd.chan_next) begin
      rres[rch] <= chan_sat;
      rch       <= rch + 2'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_delay || cmd.out_pix) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_delay) begin
      out_data <= '{result_kind: RES_DELAY, delay_ms: ms, out_pixel: '0,
                    last_pixel: 1'b0};
    end else if (cmd.out_pix) begin
      out_data <= '{result_kind: RES_PIXEL, delay_ms: '0,
                    out_pixel: (rpix[31:24] == '0) ? '0 :
                               {rpix[31:24], rres[2], rres[1], rres[0]},
                    last_pixel: rlast};
    end
  end

  always_comb begin
    stat.kind        = inq.kind;
    stat.first_frame = inq.first_frame;
    stat.pend        = pend;
    stat.dm_new      = dm_new;
    stat.full_last   = full_last;
    stat.reg_last    = reg_last;
    stat.pix_ok      = (wrow < fh) && (fw != '0);
    stat.pix_in      = pix_in;
    stat.div_done    = div_done;
    stat.alpha_zero  = (rpix[31:24] == '0);
    stat.chan_last   = (rch == 2'd2);
    stat.out_free    = !out_valid || !out_stall;
  end

endmodule

[sv/afc_ctrl.sv]
module afc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  afc_pkg::stat_t stat,
  output afc_pkg::cmd_t  cmd
);
  import afc_pkg::*;

  localparam logic [4:0] S_INIT      = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_DECODE    = 5'd2;
  localparam logic [4:0] S_CLR_ALL   = 5'd3;
  localparam logic [4:0] S_CLR_REG   = 5'd4;
  localparam logic [4:0] S_RESTORE   = 5'd5;
  localparam logic [4:0] S_RESTORE_T = 5'd6;
  localparam logic [4:0] S_HDR2      = 5'd7;
  localparam logic [4:0] S_BACKUP    = 5'd8;
  localparam logic [4:0] S_BACKUP_T  = 5'd9;
  localparam logic [4:0] S_DLY_START = 5'd10;
  localparam logic [4:0] S_DLY_WAIT  = 5'd11;
  localparam logic [4:0] S_DLY_OUT   = 5'd12;
  localparam logic [4:0] S_PIX_RD    = 5'd13;
  localparam logic [4:0] S_PIX_MUL   = 5'd14;
  localparam logic [4:0] S_PIX_WR    = 5'd15;
  localparam logic [4:0] S_RD_ADDR   = 5'd16;
  localparam logic [4:0] S_RD_DATA   = 5'd17;
  localparam logic [4:0] S_RD_CHK    = 5'd18;
  localparam logic [4:0] S_RD_START  = 5'd19;
  localparam logic [4:0] S_RD_DIV    = 5'd20;
  localparam logic [4:0] S_RD_OUT    = 5'd21;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr_all = 1'b1;
        if (stat.full_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.kind)
          KIND_HEADER: begin
            if (stat.first_frame) state_next = S_CLR_ALL;
            else if (stat.pend == DISP_CLEAR) state_next = S_CLR_REG;
            else if (stat.pend == DISP_RESTORE) state_next = S_RESTORE;
            else state_next = S_HDR2;
          end
          KIND_PIXEL: begin
            if (stat.pix_ok && stat.pix_in) begin
              state_next = S_PIX_RD;
            end else begin
              cmd.pix_adv = stat.pix_ok;
              state_next  = S_IDLE;
            end
          end
          KIND_READ: state_next = S_RD_ADDR;
          default:   state_next = S_IDLE;
        endcase
      end
      S_CLR_ALL: begin
        cmd.clr_all = 1'b1;
        if (stat.full_last) state_next = S_HDR2;
      end
      S_CLR_REG: begin
        cmd.clr_reg = 1'b1;
        if (stat.reg_last) state_next = S_HDR2;
      end
      S_RESTORE: begin
        cmd.copy_b2c = 1'b1;
        if (stat.full_last) state_next = S_RESTORE_T;
      end
      S_RESTORE_T: state_next = S_HDR2;
      S_HDR2: begin
        cmd.frame_load = 1'b1;
        state_next = (stat.dm_new == DISP_RESTORE) ? S_BACKUP : S_DLY_START;
      end
      S_BACKUP: begin
        cmd.copy_c2b = 1'b1;
        if (stat.full_last) state_next = S_BACKUP_T;
      end
      S_BACKUP_T: state_next = S_DLY_START;
      S_DLY_START: begin
        cmd.div_delay = 1'b1;
        state_next    = S_DLY_WAIT;
      end
      S_DLY_WAIT: begin
        if (stat.div_done) state_next = S_DLY_OUT;
      end
      S_DLY_OUT: begin
        if (stat.out_free) begin
          cmd.out_delay = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_PIX_RD: begin
        cmd.pix_rd = 1'b1;
        state_next = S_PIX_MUL;
      end
      S_PIX_MUL: begin
        cmd.pix_mul = 1'b1;
        state_next  = S_PIX_WR;
      end
      S_PIX_WR: begin
        cmd.pix_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_RD_ADDR: begin
        cmd.rd_addr = 1'b1;
        state_next  = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.rd_data = 1'b1;
        state_next  = S_RD_CHK;
      end
      S_RD_CHK: state_next = stat.alpha_zero ? S_RD_OUT : S_RD_START;
      S_RD_START: begin
        cmd.div_chan = 1'b1;
        state_next   = S_RD_DIV;
      end
      S_RD_DIV: begin
        if (stat.div_done) begin
          cmd.chan_next = 1'b1;
          state_next    = stat.chan_last ? S_RD_OUT : S_RD_START;
        end
      end
      S_RD_OUT: begin
        if (stat.out_free) begin
          cmd.out_pix = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[sv/afc_checker.sv]
module afc_props (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input afc_pkg::out_t out_data
);
  import afc_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Delay results carry only a delay of at least the minimum.
  a_delay_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == RES_DELAY) |->
      (out_data.delay_ms >= MIN_DELAY) && (out_data.out_pixel == '0) &&
      !out_data.last_pixel)
    else $error("malformed delay result");

  // Pixel results: no delay, and a transparent pixel reads as all zero.
  a_pixel_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == RES_PIXEL) |->
      (out_data.delay_ms == '0) &&
      ((out_data.out_pixel[31:24] != '0) || (out_data.out_pixel == '0)))
    else $error("malformed pixel result");

  // The canvas clearing pass holds off input right after reset.
  a_init_stall: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_stall && !out_valid)
    else $error("input taken during clearing pass");

endmodule

bind animated_frame_compositor afc_props u_afc_props (.*);

[tb/sv/afc_checker.sv]
`timescale 1ns / 100ps

// Watches the input, output and register channels of the compositor, keeps its
// own copy of the canvas and registers, and compares every result beat with
// the oldest predicted one.
module afc_checker
  import afc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   results_due
);

  localparam int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  logic [31:0]  canvas [DEPTH];
  logic [31:0]  backup [DEPTH];
  logic [CFG_W-1:0] width_reg, height_reg;
  int unsigned  fx, fy, fw, fh, col, row, rd_idx;
  logic [1:0]   pend;
  logic         blend;
  out_t         due_q[$];

  function automatic int unsigned scale255(int unsigned a, int unsigned b);
    return (a * b + 127) / 255;
  endfunction

  function automatic int unsigned straight(int unsigned c, int unsigned a);
    int unsigned v;
    v = (c * 255 + a / 2) / a;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic int unsigned cur_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned cur_h();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
    return height_reg;
  endfunction

  // Premultiplies one straight pixel and writes or blends it onto the canvas.
  task automatic paint(logic [31:0] px);
    int unsigned w, h, x, y, idx, sa, ia;
    logic [31:0] dst;
    logic [7:0]  pb, pg, pr, ob, og, orr, oa;
    w = cur_w();
    h = cur_h();
    x = fx + col;
    y = fy + row;
    if (x < w && y < h) begin
      idx = (y * w + x) % DEPTH;
      dst = canvas[idx];
      sa = px[31:24];
      pb = 8'(scale255(px[7:0], sa));
      pg = 8'(scale255(px[15:8], sa));
      pr = 8'(scale255(px[23:16], sa));
      if (!blend || dst[31:24] == 0) begin
        ob = pb; og = pg; orr = pr; oa = 8'(sa);
      end else begin
        ia = 255 - sa;
        ob = 8'(pb + scale255(dst[7:0], ia));
        og = 8'(pg + scale255(dst[15:8], ia));
        orr = 8'(pr + scale255(dst[23:16], ia));
        oa = 8'(sa + scale255(dst[31:24], ia));
      end
      canvas[idx] = {oa, orr, og, ob};
    end
  endtask

  task automatic predict(in_t d);
    int unsigned w, h, rx, ry, rw, rh, den, ms, total, a, x, y;
    logic [31:0] p;
    out_t r;
    w = cur_w();
    h = cur_h();
    r = '0;
    case (d.kind)
      KIND_HEADER: begin
        if (d.first_frame) begin
          foreach (canvas[i]) canvas[i] = '0;
        end else if (pend == DISP_CLEAR) begin
          // Clear the old region, clipped at the canvas edges.
          for (int unsigned rr = 0; rr < fh && fy + rr < h; rr++) begin
            for (int unsigned cc = 0; cc < fw && fx + cc < w; cc++) begin
              y = fy + rr;
              x = fx + cc;
              canvas[(y * w + x) % DEPTH] = '0;
            end
          end
        end else if (pend == DISP_RESTORE) begin
          canvas = backup;
        end
        rx = d.region_x;
        ry = d.region_y;
        rw = d.region_w;
        rh = d.region_h;
        if (rw == 0 || rh == 0 || rx + rw > w || ry + rh > h) begin
          rx = 0; ry = 0; rw = w; rh = h;
        end
        fx = rx; fy = ry; fw = rw; fh = rh;
        blend = d.blend_mode;
        pend = (d.dispose_mode == 2'd3) ? DISP_NONE : d.dispose_mode;
        if (pend == DISP_RESTORE) backup = canvas;
        col = 0;
        row = 0;
        rd_idx = 0;
        den = (d.delay_den == 0) ? 100 : d.delay_den;
        ms = (d.delay_num * 1000) / den;
        if (ms < 10) ms = 10;
        r.result_kind = RES_DELAY;
        r.delay_ms = 26'(ms);
        due_q.insert(due_q.size(), r);
      end
      KIND_PIXEL: begin
        if (row < fh && fw != 0) begin
          paint(d.pixel_bgra);
          col++;
          if (col >= fw) begin
            col = 0;
            row++;
          end
        end
      end
      KIND_READ: begin
        total = w * h;
        if (rd_idx >= total) rd_idx = 0;
        p = canvas[rd_idx % DEPTH];
        a = p[31:24];
        r.result_kind = RES_PIXEL;
        if (a != 0) begin
          r.out_pixel = {p[31:24], 8'(straight(p[23:16], a)), 8'(straight(p[15:8], a)),
                         8'(straight(p[7:0], a))};
        end
        r.last_pixel = (rd_idx == total - 1);
        rd_idx++;
        if (rd_idx >= total) rd_idx = 0;
        due_q.insert(due_q.size(), r);
      end
      default: ;
    endcase
  endtask

  assign results_due = due_q.size();

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      foreach (canvas[i]) canvas[i] = '0;
      width_reg = 9'd256;
      height_reg = 9'd256;
      fx = 0; fy = 0; fw = 0; fh = 0;
      col = 0; row = 0; rd_idx = 0;
      pend = DISP_NONE;
      blend = 1'b0;
      due_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_data);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          if (out_data.result_kind !== want.result_kind) begin
            $display("%0t: result_kind expected %0d got %0d", $time,
                     want.result_kind, out_data.result_kind);
            fail_count++;
          end
          if (out_data.delay_ms !== want.delay_ms) begin
            $display("%0t: delay_ms expected %0d got %0d", $time,
                     want.delay_ms, out_data.delay_ms);
            fail_count++;
          end
          if (out_data.out_pixel !== want.out_pixel) begin
            $display("%0t: out_pixel expected %h got %h", $time,
                     want.out_pixel, out_data.out_pixel);
            fail_count++;
          end
          if (out_data.last_pixel !== want.last_pixel) begin
            $display("%0t: last_pixel expected %0d got %0d", $time,
                     want.last_pixel, out_data.last_pixel);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict(in_data);
    end
  end

endmodule

[tb/sv/tb_animated_frame_compositor.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the frame compositor. The checker beside the block
// predicts every result; this module builds frames, pixels and readout
// steps, changes the canvas size between phases and decides pass or fail.
module tb_animated_frame_compositor;
  import afc_pkg::*;

  // Longest quiet stretch allowed. The worst case is a header that restores
  // the backup and then takes a new backup, two full passes over the store,
  // or the clearing pass right after reset.
  localparam int QUIET_LIMIT = 400000;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_t              in_data;
  logic             out_valid;
  logic             out_stall;
  out_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               results_due;

  // Sender pacing and receiver behavior.
  int  burst_left;
  int  gap_max;
  int  stall_pct;
  bit  hold_req;
  int  quiet;
  int  beats_sent;
  int  heavy_left;

  animated_frame_compositor DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  afc_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: a random stall pattern whose density is redrawn for each span,
  // with some spans that never stall. On request it holds off for a long
  // stretch so that the block backs up and stalls its input.
  initial begin
    int span;
    out_stall = 1'b0;
    stall_pct = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
      end
      if (span == 0) begin
        span = 256;
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      span--;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Any accepted beat on any channel resets the quiet counter.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offers one beat and waits for it to be taken. Beats go out in bursts;
  // between bursts the valid may drop for a random gap.
  task automatic send_beat(in_t d);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (d.kind != 2'd3) beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(20);
      gap = $urandom_range(gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Lowers valid and waits until the block has nothing left to deliver.
  // The extra cycles cover pixels still in flight, which produce no beat.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_due == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t noise_beat(logic [1:0] k);
    in_t d;
    d = {$urandom, $urandom, $urandom, $urandom};
    d.kind = k;
    return d;
  endfunction

  function automatic in_t header(bit ff, int x, int y, int w, int h, logic [1:0] dm,
                                 bit bm, int num, int den);
    in_t d;
    d = noise_beat(KIND_HEADER);
    d.first_frame = ff;
    d.region_x = 8'(x);
    d.region_y = 8'(y);
    d.region_w = 9'(w);
    d.region_h = 9'(h);
    d.dispose_mode = dm;
    d.blend_mode = bm;
    d.delay_num = 16'(num);
    d.delay_den = 16'(den);
    return d;
  endfunction

  function automatic in_t pixel(logic [31:0] bgra);
    in_t d;
    d = noise_beat(KIND_PIXEL);
    d.pixel_bgra = bgra;
    return d;
  endfunction

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(3))
      0: p[31:24] = 8'd0;
      1: p[31:24] = 8'd255;
      default: ;
    endcase
    return p;
  endfunction

  // One frame with random content on a canvas of ew x eh: a header, its
  // pixels (sometimes short, sometimes with surplus) and some readout steps.
  // Full-store passes are slow, so first frames and restores are rationed.
  task automatic random_frame(int ew, int eh);
    int rx, ry, rw, rh, npix, nread;
    bit ff;
    logic [1:0] dm;
    rx = $urandom_range(ew - 1);
    ry = $urandom_range(eh - 1);
    rw = $urandom_range(ew - rx, 1);
    rh = $urandom_range(eh - ry, 1);
    case ($urandom_range(9))
      0: rw = 0;
      1: rh = $urandom_range(511);
      2: rw = $urandom_range(511);
      default: ;
    endcase
    dm = $urandom_range(3);
    ff = ($urandom_range(19) == 0);
    if (heavy_left <= 0) begin
      ff = 1'b0;
      if (dm == DISP_RESTORE) dm = DISP_CLEAR;
    end
    if (ff || dm == DISP_RESTORE) heavy_left--;
    send_beat(header(ff, rx, ry, rw, rh, dm, $urandom_range(1),
                     $urandom_range(65535),
                     ($urandom_range(7) == 0) ? 0 : $urandom_range(65535)));
    if (rw == 0 || rh == 0 || rx + rw > ew || ry + rh > eh) npix = ew * eh;
    else npix = rw * rh;
    if (npix > 40) npix = 40;
    if ($urandom_range(5) == 0) npix = $urandom_range(npix);
    npix += $urandom_range(2);
    repeat (npix) send_beat(pixel(rand_pixel()));
    if ($urandom_range(9) == 0) send_beat(noise_beat(2'd3));
    nread = ew * eh + 2;
    if (nread > 30) nread = 30;
    repeat ($urandom_range(nread, 1)) send_beat(noise_beat(KIND_READ));
  endtask

  initial begin
    int widths[8];
    int heights[8];
    int ew, eh, phase, phase_start;
    widths  = '{0, 1, 511, 3, 5, 16, 9, 256};
    heights = '{0, 511, 1, 2, 4, 16, 3, 2};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    hold_req = 1'b0;
    burst_left = 0;
    gap_max = 4;
    beats_sent = 0;
    heavy_left = 5;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on the reset size of 256 x 256. A one-pixel frame in the
    // far corner with shortest delay, then a full-canvas fallback header that
    // applies the corner clear, takes the longest delay and asks for restore.
    send_beat(header(1'b1, 255, 255, 1, 1, DISP_CLEAR, 1'b0, 0, 0));
    send_beat(pixel(32'hFF10_80F0));
    send_beat(pixel(32'hFFFF_FFFF));
    send_beat(noise_beat(KIND_READ));
    send_beat(noise_beat(KIND_READ));
    send_beat(header(1'b0, 0, 0, 0, 5, DISP_RESTORE, 1'b1, 65535, 1));
    send_beat(pixel(32'h80FF_0001));
    send_beat(pixel(32'h0012_3456));
    // This header restores the backup first, then sets a two-pixel region.
    send_beat(header(1'b0, 0, 0, 2, 1, DISP_NONE, 1'b1, 7, 0));
    send_beat(pixel(32'h40FF_8000));
    send_beat(pixel(32'hFF00_00FF));
    // Dispose code 3 acts as none; a tiny ratio rounds up to the minimum.
    send_beat(header(1'b0, 0, 0, 2, 1, 2'd3, 1'b1, 1, 65535));
    send_beat(pixel(32'h7F80_40C0));
    send_beat(pixel(32'h0100_0000));
    send_beat(noise_beat(2'd3));
    send_beat(noise_beat(KIND_READ));
    send_beat(noise_beat(KIND_READ));
    send_beat(noise_beat(KIND_READ));
    send_beat(header(1'b0, 200, 0, 100, 1, DISP_NONE, 1'b0, 65535, 65535));
    drain();

    // Random part, phase by phase over a range of canvas sizes.
    phase = 0;
    beats_sent = 0;
    while (beats_sent < 650) begin
      write_reg(CFG_WIDTH, CFG_W'(widths[phase % 8]));
      write_reg(CFG_HEIGHT, CFG_W'(heights[phase % 8]));
      ew = (widths[phase % 8] == 0) ? 1 : (widths[phase % 8] > 256 ? 256 : widths[phase % 8]);
      eh = (heights[phase % 8] == 0) ? 1 :
           (heights[phase % 8] > 256 ? 256 : heights[phase % 8]);
      gap_max = (phase % 3 == 0) ? 0 : 6;
      if (phase == 3) begin
        // Long receiver hold while readout steps keep coming.
        hold_req = 1'b1;
        repeat (20) send_beat(noise_beat(KIND_READ));
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < 80 && beats_sent < 650) random_frame(ew, eh);
      drain();
      phase++;
    end

    wait (results_due == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[animated_frame_compositor.f]
sv/afc_pkg.sv
sv/afc_div.sv
sv/afc_dp.sv
sv/afc_ctrl.sv
sv/animated_frame_compositor.sv
sv/afc_checker.sv
tb/sv/afc_checker.sv
tb/sv/tb_animated_frame_compositor.sv
